// ===== rtl/dfd_pkg.sv =====
// Shared types and constants of the digitizer frame deframer.
`timescale 1ns / 1ps

package dfd_pkg;

	// Default sizes of one board
	localparam int DEF_SAMPLES_PER_CHANNEL = 256;
	localparam int DEF_CHANNELS_PER_BOARD  = 30;
	localparam int DEF_CHIPS               = 5;

	// Frame layout
	localparam int POS_W = 13;
	localparam logic [POS_W-1:0] POS_MAX      = 13'd8191;
	localparam logic [POS_W-1:0] TRIG_BASE    = 13'd7762;
	localparam logic [POS_W-1:0] COMBINED_POS = 13'd7792;
	localparam int SECTIONS = 5;
	localparam logic [POS_W-1:0] DATA_BEGIN [SECTIONS] =
		'{13'd3, 13'd1555, 13'd3107, 13'd4659, 13'd6211};
	localparam logic [POS_W-1:0] INFO_BEGIN [SECTIONS] =
		'{13'd1540, 13'd3092, 13'd4644, 13'd6196, 13'd7748};
	localparam logic [3:0] INFO_WORDS = 4'd13;

	// Marker words
	localparam logic [15:0] WORD_DATA_END  = 16'hBA11;
	localparam logic [15:0] WORD_INFO_END  = 16'hFACE;
	localparam logic [15:0] WORD_FRAME_END = 16'h4321;

	// Global channel sum: 7 * 64 + 255 fits in 11 bits
	localparam int CHN_W = 11;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_BOARD_ID   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PED_ENABLE = 1'b1;

	// Input item operation
	typedef enum logic {
		OP_FRAME     = 1'b0,
		OP_PED_WRITE = 1'b1
	} op_t;

	// Result kind
	typedef enum logic [1:0] {
		KIND_SAMPLE   = 2'd0,
		KIND_INFO     = 2'd1,
		KIND_TRIGGER  = 2'd2,
		KIND_COMBINED = 2'd3
	} kind_t;

	// Section tracker
	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_DATA = 2'd1,
		MODE_INFO = 2'd2
	} mode_t;

endpackage

// ===== rtl/digitizer_frame_deframer_core.sv =====
// Digitizer frame deframer: position tracking, pedestal memory and result pipeline.
`timescale 1ns / 1ps

// Takes one item per clock, back to back, while s_tready is high. A frame
// word is decoded from its frame position in the cycle it is accepted, and
// the pedestal memory is read at the same edge into stage 1. The output
// register loads from stage 1 when it is empty or m_tready is high, and
// m_tvalid shows the output register; a result passes through the registered
// read of the pedestal memory and then the output register. A pedestal write
// item goes straight into the memory and gives no result. The pedestal memory
// holds CHANNELS_PER_BOARD*SAMPLES_PER_CHANNEL words that read as garbage until
// written; it has no clearing pass, so the block is ready right after reset.
// Stage 1 and the output register form a two-deep pipeline: while m_tready is
// low a full output register holds, stage 1 holds behind it, and s_tready drops
// only when both are occupied.
module digitizer_frame_deframer_core
	import dfd_pkg::*;
#(
	parameter int SAMPLES_PER_CHANNEL = DEF_SAMPLES_PER_CHANNEL,
	parameter int CHANNELS_PER_BOARD  = DEF_CHANNELS_PER_BOARD,
	parameter int CHIPS               = DEF_CHIPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [2:0]           cfg_data,
	// input items
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,  // word[15:0], ped_channel[20:16], ped_sample[28:21]
	input  logic [1:0]           s_tuser,  // operation[0], frame_start[1]
	// result items
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,  // channel[7:0], sample_index[15:8], value[32:16],
	                                       // chip[35:33], slot[39:36]
	output logic [1:0]           m_tuser,  // kind[1:0]
	output logic                 m_tlast   // channel_last
);

	localparam int SC_W      = $clog2(SAMPLES_PER_CHANNEL);
	localparam int CH_IDX_W  = $clog2(CHANNELS_PER_BOARD);
	localparam int PED_DEPTH = CHANNELS_PER_BOARD * SAMPLES_PER_CHANNEL;
	localparam int ADDR_W    = $clog2(PED_DEPTH);
	localparam int TRIG_PER_CHIP = CHANNELS_PER_BOARD / CHIPS;
	localparam int TRIG_END  = 7762 + CHIPS * TRIG_PER_CHIP;

	// Input fields
	logic              in_op;
	logic [15:0]       in_word;
	logic              in_fs;
	logic [4:0]        in_pc;
	logic [7:0]        in_ps;
	assign in_op   = s_tuser[0];
	assign in_fs   = s_tuser[1];
	assign in_word = s_tdata[15:0];
	assign in_pc   = s_tdata[20:16];
	assign in_ps   = s_tdata[28:21];

	// Configuration registers
	logic [2:0] board_id_q;
	logic       ped_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_id_q   <= '0;
			ped_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOARD_ID:   board_id_q   <= cfg_data;
				REG_PED_ENABLE: ped_enable_q <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	// Frame state
	logic [POS_W-1:0] pos_q;
	mode_t            mode_q;
	logic [2:0]       chip_q;
	logic [3:0]       info_q;
	logic [SC_W-1:0]  sc_q;
	logic [7:0]       cc_q;

	// Handshake
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic in_acc;
	logic frame_acc;
	logic ped_wr;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign in_acc    = s_tvalid && s_tready;
	assign frame_acc = in_acc && (in_op == OP_FRAME);
	assign ped_wr    = in_acc && (in_op == OP_PED_WRITE)
		&& (int'(in_pc) < CHANNELS_PER_BOARD) && (int'(in_ps) < SAMPLES_PER_CHANNEL);

	// Position of this word and section state after frame start and section begins
	logic [POS_W-1:0] pos_cur;
	logic [POS_W-1:0] pos_nxt;
	logic             is_comb;
	logic             is_trig;
	logic             special;
	mode_t            mode_c, mode_b;
	logic [2:0]       chip_c, chip_b;
	logic [3:0]       info_c, info_b;
	logic [SC_W-1:0]  sc_c, sc_b;
	logic [7:0]       cc_c;
	logic             data_end;
	logic             info_end;
	logic             last_smp;

	always_comb begin
		pos_cur = in_fs ? '0 : pos_q;
		pos_nxt = (pos_cur < POS_MAX) ? pos_cur + 1'b1 : POS_MAX;
		is_comb = (pos_cur == COMBINED_POS);
		is_trig = (TRIG_PER_CHIP > 0) && (pos_cur >= TRIG_BASE)
			&& (int'(pos_cur) < TRIG_END);
		special = is_comb || is_trig;

		mode_c = in_fs ? MODE_IDLE : mode_q;
		chip_c = in_fs ? '0 : chip_q;
		info_c = in_fs ? '0 : info_q;
		sc_c   = in_fs ? '0 : sc_q;
		cc_c   = in_fs ? '0 : cc_q;

		mode_b = mode_c;
		chip_b = chip_c;
		info_b = info_c;
		sc_b   = sc_c;
		for (int k = 0; k < SECTIONS; k++) begin
			if (pos_cur == DATA_BEGIN[k]) begin
				mode_b = MODE_DATA;
				sc_b   = '0;
			end
			if (pos_cur == INFO_BEGIN[k]) begin
				mode_b = MODE_INFO;
				chip_b = 3'(k);
				info_b = '0;
			end
		end

		data_end = (in_word == WORD_DATA_END) || (in_word == WORD_FRAME_END);
		info_end = (in_word == WORD_INFO_END) || (in_word == WORD_FRAME_END);
		last_smp = (int'(sc_b) == SAMPLES_PER_CHANNEL - 1);
	end

	// Next frame state
	mode_t           mode_d;
	logic [2:0]      chip_d;
	logic [3:0]      info_d;
	logic [SC_W-1:0] sc_d;
	logic [7:0]      cc_d;

	always_comb begin
		mode_d = mode_b;
		chip_d = chip_b;
		info_d = info_b;
		sc_d   = sc_b;
		cc_d   = cc_c;
		if (special) begin
			mode_d = mode_c;
			chip_d = chip_c;
			info_d = info_c;
			sc_d   = sc_c;
		end else begin
			unique case (mode_b)
				MODE_DATA: begin
					if (data_end) begin
						mode_d = MODE_IDLE;
					end else if (last_smp) begin
						sc_d = '0;
						cc_d = (cc_c == 8'hFF) ? cc_c : cc_c + 8'd1;
					end else begin
						sc_d = sc_b + 1'b1;
					end
				end
				MODE_INFO: begin
					if (info_end) begin
						mode_d = MODE_IDLE;
					end else begin
						info_d = info_b + 4'd1;
						if (info_b + 4'd1 >= INFO_WORDS) mode_d = MODE_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mode_q <= MODE_IDLE;
			chip_q <= '0;
			info_q <= '0;
			sc_q   <= '0;
			cc_q   <= '0;
		end else if (frame_acc) begin
			pos_q  <= pos_nxt;
			mode_q <= mode_d;
			chip_q <= chip_d;
			info_q <= info_d;
			sc_q   <= sc_d;
			cc_q   <= cc_d;
		end
	end

	// Trigger chip and slot from the offset past the trigger base
	logic [6:0] trig_off;
	logic [2:0] trig_chip;
	logic [6:0] trig_rem;

	always_comb begin
		trig_off  = 7'(pos_cur - TRIG_BASE);
		trig_chip = '0;
		for (int c = 1; c < CHIPS; c++) begin
			if (int'(trig_off) >= c * TRIG_PER_CHIP) trig_chip = 3'(c);
		end
		trig_rem = trig_off - 7'(trig_chip) * 7'(TRIG_PER_CHIP);
	end

	// Result fields of the current word
	logic            res_valid;
	kind_t           res_kind;
	logic [7:0]      res_ch;
	logic [2:0]      res_chip;
	logic [3:0]      res_slot;
	logic            res_last;
	logic            res_ped;
	logic [CHN_W-1:0] chn_sum;

	always_comb begin
		chn_sum   = CHN_W'(board_id_q) * CHN_W'(CHANNELS_PER_BOARD) + CHN_W'(cc_c);
		res_valid = 1'b0;
		res_kind  = KIND_SAMPLE;
		res_ch    = '0;
		res_chip  = '0;
		res_slot  = '0;
		res_last  = 1'b0;
		res_ped   = 1'b0;
		priority if (is_comb) begin
			res_valid = 1'b1;
			res_kind  = KIND_COMBINED;
		end else if (is_trig) begin
			res_valid = 1'b1;
			res_kind  = KIND_TRIGGER;
			res_chip  = trig_chip;
			res_slot  = trig_rem[3:0];
		end else if (mode_b == MODE_DATA) begin
			res_valid = !data_end;
			res_kind  = KIND_SAMPLE;
			res_ch    = (chn_sum > CHN_W'(255)) ? 8'hFF : chn_sum[7:0];
			res_last  = last_smp;
			res_ped   = ped_enable_q && (int'(cc_c) < CHANNELS_PER_BOARD);
		end else if (mode_b == MODE_INFO) begin
			res_valid = !info_end;
			res_kind  = KIND_INFO;
			res_chip  = chip_b;
			res_slot  = info_b;
		end else begin
			res_valid = 1'b0;
		end
	end

	// Pedestal memory: one write or one registered read per cycle
	logic [15:0]       ped_mem [PED_DEPTH];
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [15:0]       ped_rd_s1;

	assign wr_addr = ADDR_W'(in_pc) * ADDR_W'(SAMPLES_PER_CHANNEL) + ADDR_W'(in_ps);
	assign rd_addr = ADDR_W'(cc_c[CH_IDX_W-1:0]) * ADDR_W'(SAMPLES_PER_CHANNEL)
		+ ADDR_W'(sc_b);

	always_ff @(posedge clk) begin
		if (ped_wr) ped_mem[wr_addr] <= in_word;
	end

	always_ff @(posedge clk) begin
		if (frame_acc) ped_rd_s1 <= ped_mem[rd_addr];
	end

	// Stage 1: decoded result waiting for pedestal data
	kind_t       kind_s1;
	logic [7:0]  ch_s1;
	logic [7:0]  sidx_s1;
	logic [15:0] word_s1;
	logic [2:0]  chip_s1;
	logic [3:0]  slot_s1;
	logic        last_s1;
	logic        ped_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= frame_acc && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			kind_s1 <= res_kind;
			ch_s1   <= res_ch;
			sidx_s1 <= (res_kind == KIND_SAMPLE) ? 8'(sc_b) : 8'd0;
			word_s1 <= in_word;
			chip_s1 <= res_chip;
			slot_s1 <= res_slot;
			last_s1 <= res_last;
			ped_s1  <= res_ped;
		end
	end

	// Output register
	kind_t       out_kind_q;
	logic [7:0]  out_ch_q;
	logic [7:0]  out_sidx_q;
	logic [16:0] out_value_q;
	logic [2:0]  out_chip_q;
	logic [3:0]  out_slot_q;
	logic        out_last_q;
	logic [16:0] value_s1;

	assign value_s1 = {1'b0, word_s1} - (ped_s1 ? {1'b0, ped_rd_s1} : 17'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_kind_q  <= kind_s1;
			out_ch_q    <= ch_s1;
			out_sidx_q  <= sidx_s1;
			out_value_q <= value_s1;
			out_chip_q  <= chip_s1;
			out_slot_q  <= slot_s1;
			out_last_q  <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_slot_q, out_chip_q, out_value_q, out_sidx_q, out_ch_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	// A stalled stage-1 item blocks new input
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while stage 1 is blocked");

	// A stalled stage-1 item keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(word_s1) && $stable(kind_s1)))
		else $error("stage 1 item changed while stalled");

	// Only sample results end a channel
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_SAMPLE))
		else $error("channel end on a non-sample result");
`endif

endmodule
